// ===== src/sem_pkg.sv =====
package sem_pkg;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int DIM_W  = 11;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
  localparam int MIN_DIM = 3;

  // gray = (r+g+b)/3 as (sum * 683) >> 11, exact for sums up to 765
  localparam int SUM_W = 10;
  localparam int GRAY_PROD_W = 20;
  localparam logic [SUM_W-1:0] GRAY_RECIP = 10'd683;
  localparam int GRAY_SHIFT = 11;

  localparam int PIX_W = 8;
  localparam int ABS_W = 10;
  localparam int SQ_W  = 21;
  localparam int RAD_W = 16;
  localparam int REM_W = 10;
  localparam int SQRT_STAGES = 4;

  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic             last;
  } tag_t;

endpackage

// ===== src/sem_ram.sv =====
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sem_sqrt.sv =====
module sem_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_sat,
  input  logic [sem_pkg::RAD_W-1:0]     in_radicand,
  input  sem_pkg::tag_t                 in_tag,
  output logic                          out_valid,
  output logic [sem_pkg::PIX_W-1:0]     out_root,
  output sem_pkg::tag_t                 out_tag
);

  localparam int STAGES = sem_pkg::SQRT_STAGES;
  localparam int RW = sem_pkg::REM_W;
  localparam int PW = sem_pkg::PIX_W;
  localparam int SW = RW + PW;

  // one radix-4 digit: bring down two radicand bits, try (4*root+1)
  function automatic logic [SW-1:0] sqrt_step(input logic [RW-1:0] rem,
                                              input logic [PW-1:0] root,
                                              input logic [1:0] pair);
    logic [RW+1:0] part;
    logic [RW+1:0] trial;
    logic [SW-1:0] res;
    part  = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (part >= trial) begin
      res = {RW'(part - trial), root[PW-2:0], 1'b1};
    end else begin
      res = {part[RW-1:0], root[PW-2:0], 1'b0};
    end
    return res;
  endfunction

  logic                      st_valid [STAGES];
  logic [RW-1:0]             st_rem   [STAGES];
  logic [PW-1:0]             st_root  [STAGES];
  logic [sem_pkg::RAD_W-1:0] st_rad   [STAGES];
  logic                      st_sat   [STAGES];
  sem_pkg::tag_t             st_tag   [STAGES];

  logic                      pv_valid [STAGES];
  logic [RW-1:0]             pv_rem   [STAGES];
  logic [PW-1:0]             pv_root  [STAGES];
  logic [sem_pkg::RAD_W-1:0] pv_rad   [STAGES];
  logic                      pv_sat   [STAGES];
  sem_pkg::tag_t             pv_tag   [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [SW-1:0] step_a;
    logic [SW-1:0] step_b;

    if (g == 0) begin : g_first
      assign pv_valid[g] = in_valid;
      assign pv_rem[g]   = '0;
      assign pv_root[g]  = '0;
      assign pv_rad[g]   = in_radicand;
      assign pv_sat[g]   = in_sat;
      assign pv_tag[g]   = in_tag;
    end else begin : g_next
      assign pv_valid[g] = st_valid[g-1];
      assign pv_rem[g]   = st_rem[g-1];
      assign pv_root[g]  = st_root[g-1];
      assign pv_rad[g]   = st_rad[g-1];
      assign pv_sat[g]   = st_sat[g-1];
      assign pv_tag[g]   = st_tag[g-1];
    end

    assign step_a = sqrt_step(pv_rem[g], pv_root[g], pv_rad[g][sem_pkg::RAD_W-1-4*g -: 2]);
    assign step_b = sqrt_step(step_a[SW-1:PW], step_a[PW-1:0],
                              pv_rad[g][sem_pkg::RAD_W-3-4*g -: 2]);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[g] <= 1'b0;
      end else if (en) begin
        st_valid[g] <= pv_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[g]  <= step_b[SW-1:PW];
        st_root[g] <= step_b[PW-1:0];
        st_rad[g]  <= pv_rad[g];
        st_sat[g]  <= pv_sat[g];
        st_tag[g]  <= pv_tag[g];
      end
    end
  end

  assign out_valid = st_valid[STAGES-1];
  assign out_root  = st_sat[STAGES-1] ? {PW{1'b1}} : st_root[STAGES-1];
  assign out_tag   = st_tag[STAGES-1];

endmodule

// ===== src/sem_grad.sv =====
module sem_grad (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [sem_pkg::PIX_W-1:0]     win [9],
  input  sem_pkg::tag_t                 in_tag,
  output logic                          out_valid,
  output logic                          out_sat,
  output logic [sem_pkg::RAD_W-1:0]     out_radicand,
  output sem_pkg::tag_t                 out_tag
);

  localparam int AW = sem_pkg::ABS_W;
  localparam int GW = AW + 1;

  logic [AW-1:0] x_pos, x_neg, y_pos, y_neg;
  logic signed [GW-1:0] gx, gy;
  logic [AW-1:0] ax, ay;
  logic [AW-1:0] ax_q, ay_q;
  logic          abs_valid;
  sem_pkg::tag_t abs_tag;
  logic [sem_pkg::SQ_W-1:0] sq;
  logic          sq_valid;
  sem_pkg::tag_t sq_tag;

  // window rows: 0..2 oldest line, 6..8 newest, column 2 is the newest pixel
  assign x_pos = AW'(win[2]) + AW'({win[5], 1'b0}) + AW'(win[8]);
  assign x_neg = AW'(win[0]) + AW'({win[3], 1'b0}) + AW'(win[6]);
  assign y_pos = AW'(win[0]) + AW'({win[1], 1'b0}) + AW'(win[2]);
  assign y_neg = AW'(win[6]) + AW'({win[7], 1'b0}) + AW'(win[8]);

  assign gx = $signed({1'b0, x_pos}) - $signed({1'b0, x_neg});
  assign gy = $signed({1'b0, y_pos}) - $signed({1'b0, y_neg});
  assign ax = gx[GW-1] ? AW'(-gx) : AW'(gx);
  assign ay = gy[GW-1] ? AW'(-gy) : AW'(gy);

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_valid <= 1'b0;
      sq_valid  <= 1'b0;
    end else if (en) begin
      abs_valid <= in_valid;
      sq_valid  <= abs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_q    <= ax;
      ay_q    <= ay;
      abs_tag <= in_tag;
      sq      <= sem_pkg::SQ_W'(ax_q * ax_q) + sem_pkg::SQ_W'(ay_q * ay_q);
      sq_tag  <= abs_tag;
    end
  end

  assign out_valid    = sq_valid;
  assign out_sat      = |sq[sem_pkg::SQ_W-1:sem_pkg::RAD_W];
  assign out_radicand = sq[sem_pkg::RAD_W-1:0];
  assign out_tag      = sq_tag;

endmodule

// ===== src/sobel_edge_magnitude.sv =====
// 3x3 sobel gradient magnitude over a raster-order rgba pixel stream.
// pixel channel: pixel_valid / pixel_stall with red, green, blue, alpha;
// a request is taken at a clock edge with valid high and stall low.
// result channel: result_valid / result_stall with magnitude (floor of
// sqrt(gx^2+gy^2), saturated at 255), center_alpha and frame_end.
// only interior pixels give a result; it leaves once the pixel one row and
// one column past its center has been taken. frame_end marks the last one.
// one pixel per cycle is sustained while no result is held; the line stores
// are read at the pixel's column and written back from the p1 registers
// when the pipeline next moves, never at the entry being read. a pixel
// passes the line store read and p1 registers, the window, the gradient
// and square registers and the square root pipeline (two root bits per stage).
// when the receiver stalls with a result waiting, the whole pipeline holds
// and pixel_stall rises in the same cycle.
// image_width (0x0) and image_height (0x4) are clamped to 3..MAX; writing
// either restarts the frame at column 0, row 0. write them only when idle.
// reset restores 640 x 480 and clears the window and counters; line store
// contents are left as they are.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sem_pkg::ADDR_W-1:0]    paddr,
  input  logic [sem_pkg::DATA_W-1:0]    pwdata,
  output logic [sem_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic [7:0]                    alpha,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [7:0]                    magnitude,
  output logic [7:0]                    center_alpha,
  output logic                          frame_end
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int DW  = sem_pkg::DIM_W;
  localparam int CWX = (XW + 1 > DW) ? XW + 1 : DW;
  localparam int CWY = (YW + 1 > DW) ? YW + 1 : DW;
  localparam int PW  = sem_pkg::PIX_W;

  logic [DW-1:0] image_width, image_height;
  logic [CWX-1:0] w_ext, w_eff;
  logic [CWY-1:0] h_ext, h_eff;
  logic [XW-1:0] w_last;
  logic [YW-1:0] h_last;
  logic          cfg_wr;

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic          adv;
  logic          accept;

  logic [sem_pkg::SUM_W-1:0]       rgb_sum;
  logic [sem_pkg::GRAY_PROD_W-1:0] gray_prod;
  logic [PW-1:0]                   gray;

  logic          p1_valid;
  logic [XW-1:0] p1_col;
  logic [PW-1:0] p1_gray;
  logic [PW-1:0] p1_alpha;
  logic          p1_interior;
  logic          p1_last;
  logic          p1_wr;

  logic [PW-1:0] older_rd, newer_rd, alpha_rd;

  logic [PW-1:0] win [9];
  logic [PW-1:0] win_alpha;
  logic          p2_valid;
  sem_pkg::tag_t p2_tag;

  logic          grad_valid;
  logic          grad_sat;
  logic [sem_pkg::RAD_W-1:0] grad_radicand;
  sem_pkg::tag_t grad_tag;
  sem_pkg::tag_t out_tag;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sem_pkg::WIDTH_RESET;
      image_height <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        sem_pkg::REG_WIDTH:  image_width  <= pwdata[DW-1:0];
        sem_pkg::REG_HEIGHT: image_height <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sem_pkg::REG_WIDTH:  prdata = sem_pkg::DATA_W'(image_width);
      sem_pkg::REG_HEIGHT: prdata = sem_pkg::DATA_W'(image_height);
      default:             prdata = '0;
    endcase
  end

  assign w_ext = CWX'(image_width);
  assign h_ext = CWY'(image_height);
  assign w_eff = (w_ext < CWX'(sem_pkg::MIN_DIM)) ? CWX'(sem_pkg::MIN_DIM) :
                 (w_ext > CWX'(MAX_WIDTH)) ? CWX'(MAX_WIDTH) : w_ext;
  assign h_eff = (h_ext < CWY'(sem_pkg::MIN_DIM)) ? CWY'(sem_pkg::MIN_DIM) :
                 (h_ext > CWY'(MAX_HEIGHT)) ? CWY'(MAX_HEIGHT) : h_ext;
  assign w_last = XW'(w_eff - CWX'(1));
  assign h_last = YW'(h_eff - CWY'(1));

  // pipeline moves as a whole unless a finished result is held
  assign adv         = !result_valid || !result_stall;
  assign pixel_stall = !adv;
  assign accept      = pixel_valid && adv;

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + YW'(1);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

  assign rgb_sum   = sem_pkg::SUM_W'(red) + sem_pkg::SUM_W'(green) + sem_pkg::SUM_W'(blue);
  assign gray_prod = sem_pkg::GRAY_PROD_W'(rgb_sum) * sem_pkg::GRAY_PROD_W'(sem_pkg::GRAY_RECIP);
  assign gray      = gray_prod[sem_pkg::GRAY_SHIFT +: PW];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_col      <= col;
      p1_gray     <= gray;
      p1_alpha    <= alpha;
      p1_interior <= (col >= XW'(2)) && (row >= YW'(2));
      p1_last     <= (col == w_last) && (row == h_last);
    end
  end

  // read at request, write back the shifted column from the p1 registers when the pipeline next moves
  assign p1_wr = adv && p1_valid;

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (p1_wr),
    .waddr (p1_col),
    .wdata (newer_rd),
    .re    (accept),
    .raddr (col),
    .rdata (older_rd)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (p1_wr),
    .waddr (p1_col),
    .wdata (p1_gray),
    .re    (accept),
    .raddr (col),
    .rdata (newer_rd)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_alpha (
    .clk   (clk),
    .we    (p1_wr),
    .waddr (p1_col),
    .wdata (p1_alpha),
    .re    (accept),
    .raddr (col),
    .rdata (alpha_rd)
  );

  // 3x3 window shifts left by one column per pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
      win_alpha <= '0;
      p2_valid  <= 1'b0;
    end else if (adv) begin
      p2_valid <= p1_valid && p1_interior;
      if (p1_valid) begin
        for (int i = 0; i < 3; i++) begin
          win[i*3]   <= win[i*3+1];
          win[i*3+1] <= win[i*3+2];
        end
        win[2]    <= older_rd;
        win[5]    <= newer_rd;
        win[8]    <= p1_gray;
        win_alpha <= alpha_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p1_valid) begin
      p2_tag.alpha <= win_alpha;
      p2_tag.last  <= p1_last;
    end
  end

  sem_grad u_grad (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (p2_valid),
    .win          (win),
    .in_tag       (p2_tag),
    .out_valid    (grad_valid),
    .out_sat      (grad_sat),
    .out_radicand (grad_radicand),
    .out_tag      (grad_tag)
  );

  sem_sqrt u_sqrt (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (grad_valid),
    .in_sat      (grad_sat),
    .in_radicand (grad_radicand),
    .in_tag      (grad_tag),
    .out_valid   (result_valid),
    .out_root    (magnitude),
    .out_tag     (out_tag)
  );

  assign center_alpha = out_tag.alpha;
  assign frame_end    = out_tag.last;

  // raster position stays inside the clamped frame
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (col <= w_last) && (row <= h_last))
    else $error("raster position outside frame");

  // the last pixel of a frame wraps the position back to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_wr && (col == w_last) && (row == h_last) |=> (col == '0) && (row == '0))
    else $error("frame did not wrap");

  // a held result freezes the line store write-back as well
  a_hold_no_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !p1_wr && !accept)
    else $error("pipeline moved while result held");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 1024;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 16;

  typedef struct packed {
    logic [7:0] magnitude;
    logic [7:0] center_alpha;
    logic       frame_end;
  } edge_result_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [sem_pkg::ADDR_W-1:0] paddr;
  logic [sem_pkg::DATA_W-1:0] pwdata;
  logic [sem_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       pixel_valid;
  logic                       pixel_stall;
  logic [7:0]                 red;
  logic [7:0]                 green;
  logic [7:0]                 blue;
  logic [7:0]                 alpha;
  logic                       result_valid;
  logic                       result_stall;
  logic [7:0]                 magnitude;
  logic [7:0]                 center_alpha;
  logic                       frame_end;

  // shadow of the block: registers, line stores, window and raster position
  logic [sem_pkg::DIM_W-1:0] cfg_width;
  logic [sem_pkg::DIM_W-1:0] cfg_height;
  logic [7:0]       gray_older [MAX_DIM];
  logic [7:0]       gray_newer [MAX_DIM];
  logic [7:0]       alpha_above_line [MAX_DIM];
  logic [7:0]       win [9];
  logic [7:0]       win_center_alpha;
  int unsigned      col;
  int unsigned      row;

  edge_result_t edges_due[$];
  int unsigned  errors;
  bit           gaps_on;
  bit           stalls_on;
  bit           hold_results;

  sobel_edge_magnitude #(
    .MAX_WIDTH  (MAX_DIM),
    .MAX_HEIGHT (MAX_DIM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .magnitude    (magnitude),
    .center_alpha (center_alpha),
    .frame_end    (frame_end)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic flag_mismatch(input string what);
    if (errors < 20) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
    errors++;
  endtask

  function automatic int unsigned clamp_dim(input logic [sem_pkg::DIM_W-1:0] v);
    if (v < sem_pkg::MIN_DIM) return sem_pkg::MIN_DIM;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // floor of the square root, saturated to 255
  function automatic logic [7:0] gradient_root(input int unsigned s);
    int unsigned r;
    int unsigned t;
    if (s >= 65536) return 8'd255;
    r = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = r | b;
      if (t * t <= s) r = t;
    end
    return r[7:0];
  endfunction

  // advance the shadow by one accepted pixel and queue the result it releases
  function automatic void advance_window(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] a);
    int unsigned  w;
    int unsigned  h;
    int unsigned  gray;
    int           gx;
    int           gy;
    logic [7:0]   a_above;
    edge_result_t res;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    gray = (int'(r) + int'(g) + int'(b)) / 3;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = gray_older[col];
    win[5] = gray_newer[col];
    win[8] = gray[7:0];
    gray_older[col] = gray_newer[col];
    gray_newer[col] = gray[7:0];
    a_above = alpha_above_line[col];
    alpha_above_line[col] = a;
    res.center_alpha = win_center_alpha;
    win_center_alpha = a_above;
    if (col >= 2 && row >= 2) begin
      gx = int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
         - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]);
      gy = int'(win[0]) + 2 * int'(win[1]) + int'(win[2])
         - int'(win[6]) - 2 * int'(win[7]) - int'(win[8]);
      res.magnitude = gradient_root(gx * gx + gy * gy);
      res.frame_end = (col == w - 1) && (row == h - 1);
      edges_due.push_back(res);
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (!gaps_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // full-range noise, moderate texture or nearly flat areas
  function automatic int unsigned pick_spread();
    case ($urandom_range(0, 2))
      0: return 255;
      1: return 48;
      default: return 6;
    endcase
  endfunction

  // called at a falling edge; returns at a falling edge with the bus idle again
  task automatic check_register(input logic idx, input logic [sem_pkg::DATA_W-1:0] want);
    logic [sem_pkg::DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== want) begin
      flag_mismatch($sformatf("register %0d reads %0d, expected %0d", idx, got, want));
    end
  endtask

  // the read-back that follows takes over the bus right after the access
  task automatic write_register(input logic idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == sem_pkg::REG_WIDTH) cfg_width = value[sem_pkg::DIM_W-1:0];
    else cfg_height = value[sem_pkg::DIM_W-1:0];
    col = 0;
    row = 0;
    @(negedge clk);
    check_register(idx, value & 32'h7FF);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    int unsigned gap;
    pixel_valid <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    alpha       <= a;
    do @(posedge clk); while (pixel_stall);
    advance_window(r, g, b, a);
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_pixels(input int unsigned count, input int unsigned spread);
    int unsigned base;
    base = $urandom_range(0, 255 - spread);
    repeat (count) begin
      send_pixel(8'(base + $urandom_range(0, spread)),
                 8'(base + $urandom_range(0, spread)),
                 8'(base + $urandom_range(0, spread)),
                 8'($urandom_range(0, 255)));
    end
    pixel_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (edges_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic test_register_access();
    check_register(sem_pkg::REG_WIDTH, 32'(sem_pkg::WIDTH_RESET));
    check_register(sem_pkg::REG_HEIGHT, 32'(sem_pkg::HEIGHT_RESET));
  endtask

  task automatic test_directed_frames();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_register(sem_pkg::REG_WIDTH, 3);
    write_register(sem_pkg::REG_HEIGHT, 3);
    // white left column, black right column: gradient saturates
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        case (x)
          0: send_pixel(8'hFF, 8'hFF, 8'hFF, (y == 1) ? 8'h00 : 8'hFF);
          1: send_pixel(8'hFF, 8'h00, 8'h00, (y == 1) ? 8'hFF : 8'h00);
          default: send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        endcase
      end
    end
    pixel_valid <= 1'b0;
    wait_drained();
    // partial frame, then a write restarts at the top left
    send_pixels(4, 255);
    wait_drained();
    // both out of range low, clamped to 3
    write_register(sem_pkg::REG_WIDTH, 0);
    write_register(sem_pkg::REG_HEIGHT, 2);
    // flat gray 1 from different channel mixes with the same sum: zero gradient
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        case (x)
          0: send_pixel(8'd1, 8'd1, 8'd1, (x == 1 && y == 1) ? 8'h5A : 8'hFF);
          1: send_pixel(8'd2, 8'd1, 8'd0, (x == 1 && y == 1) ? 8'h5A : 8'hFF);
          default: send_pixel(8'd0, 8'd0, 8'd3, 8'hFF);
        endcase
      end
    end
    pixel_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_result_backpressure();
    gaps_on = 1'b0;
    write_register(sem_pkg::REG_WIDTH, 8);
    write_register(sem_pkg::REG_HEIGHT, 6);
    hold_results = 1'b1;
    send_pixels(96, pick_spread());
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned ew;
    int unsigned eh;
    int unsigned count;
    sent = 0;
    while (sent < 560) begin
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 2);
      else if ($urandom_range(0, 4) == 0) w = $urandom_range(13, 32);
      else w = $urandom_range(3, 12);
      if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 2);
      else h = $urandom_range(3, 8);
      ew = clamp_dim(sem_pkg::DIM_W'(w));
      eh = clamp_dim(sem_pkg::DIM_W'(h));
      gaps_on   = $urandom_range(0, 9) < 7;
      stalls_on = $urandom_range(0, 9) < 7;
      if ($urandom_range(0, 1) == 1) begin
        write_register(sem_pkg::REG_WIDTH, w);
        write_register(sem_pkg::REG_HEIGHT, h);
      end else begin
        write_register(sem_pkg::REG_HEIGHT, h);
        write_register(sem_pkg::REG_WIDTH, w);
      end
      // whole frames, often followed by a frame cut short
      count = $urandom_range(1, 3) * ew * eh;
      if ($urandom_range(0, 2) != 0) count += $urandom_range(1, ew * eh - 1);
      send_pixels(count, pick_spread());
      sent += count;
      wait_drained();
    end
  endtask

  // sizes above the top clamp to the largest dimension, paired with low sizes that clamp to 3
  task automatic test_largest_frames();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    write_register(sem_pkg::REG_WIDTH, 1);
    write_register(sem_pkg::REG_HEIGHT, 1500);
    send_pixels(60, pick_spread());
    wait_drained();
    write_register(sem_pkg::REG_WIDTH, 2047);
    write_register(sem_pkg::REG_HEIGHT, 2);
    send_pixels(24, pick_spread());
    wait_drained();
  endtask

  // result side stall pattern, with one long hold on request
  initial begin : result_sink
    int unsigned pick;
    int unsigned len;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_results = 1'b0;
        result_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (!stalls_on || pick < 75) begin
          result_stall <= 1'b0;
        end else begin
          result_stall <= 1'b1;
          len = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
          repeat (len) @(negedge clk);
        end
      end
    end
  end

  initial begin : result_compare
    edge_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
        if (edges_due.size() == 0) begin
          flag_mismatch("result with none outstanding");
        end else begin
          want = edges_due.pop_front();
          if (magnitude !== want.magnitude) begin
            flag_mismatch($sformatf("magnitude %0d, expected %0d", magnitude, want.magnitude));
          end
          if (center_alpha !== want.center_alpha) begin
            flag_mismatch($sformatf("center_alpha %0d, expected %0d",
                                    center_alpha, want.center_alpha));
          end
          if (frame_end !== want.frame_end) begin
            flag_mismatch($sformatf("frame_end %0b, expected %0b", frame_end, want.frame_end));
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pixel_valid  = 1'b0;
    red          = 8'h00;
    green        = 8'h00;
    blue         = 8'h00;
    alpha        = 8'h00;
    errors       = 0;
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    hold_results = 1'b0;
    cfg_width    = sem_pkg::WIDTH_RESET;
    cfg_height   = sem_pkg::HEIGHT_RESET;
    col          = 0;
    row          = 0;
    win_center_alpha = 8'h00;
    for (int i = 0; i < 9; i++) win[i] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_register_access();
    test_directed_frames();
    test_result_backpressure();
    test_random_frames();
    test_largest_frames();
    while (edges_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sem_pkg.sv
src/sem_ram.sv
src/sem_sqrt.sv
src/sem_grad.sv
src/sobel_edge_magnitude.sv
tb/sv/testbench.sv
